// ===== hdl/gcva_pkg.sv =====
// Shared types and constants for the gradient center vote accumulator.
`timescale 1ns / 1ps
package gcva_pkg;

  localparam int SCORE_W = 52;
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // Widths of the vote datapath, sized for grids up to 256 by 256 cells.
  // Dot product n <= |d|*|g| < 2^24, so n*n*weight < 2^56. The quotient
  // n*n*weight/d2 <= |g|^2*weight < 2^39.
  localparam int N_W   = 24;
  localparam int NN_W  = 2 * N_W;
  localparam int DVD_W = NN_W + 8;
  localparam int Q_W   = 39;
  localparam int D2_W  = DVD_W - Q_W;

  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_VOTE   = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

endpackage

// ===== hdl/gcva_req_if.sv =====
// Request channel: kind, cell address, weight and gradient payload.
`timescale 1ns / 1ps
interface gcva_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [5:0]         col;
  logic [5:0]         row;
  logic [7:0]         weight_value;
  logic signed [15:0] grad_x;
  logic signed [15:0] grad_y;

  modport source (output valid, kind, col, row, weight_value, grad_x, grad_y,
                  input ready);
  modport sink   (input valid, kind, col, row, weight_value, grad_x, grad_y,
                  output ready);
endinterface

// ===== hdl/gcva_rsp_if.sv =====
// Response channel: score read back from the score grid.
`timescale 1ns / 1ps
interface gcva_rsp_if;
  import gcva_pkg::*;
  logic               valid;
  logic               ready;
  logic [SCORE_W-1:0] score;

  modport source (output valid, score, input ready);
  modport sink   (input valid, score, output ready);
endinterface

// ===== hdl/gcva_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module gcva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/gcva_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, tag carried along.
`timescale 1ns / 1ps
module gcva_div #(
  parameter int AW = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [gcva_pkg::DVD_W-1:0] in_dvd,
  input  logic [gcva_pkg::D2_W-1:0]  in_d2,
  input  logic [AW-1:0]              in_idx,
  output logic                       out_valid,
  output logic [gcva_pkg::Q_W-1:0]   out_q,
  output logic [AW-1:0]              out_idx,
  output logic                       busy
);
  import gcva_pkg::*;

  logic [D2_W-1:0] rem  [Q_W+1];
  logic [Q_W-1:0]  low  [Q_W+1];
  logic [Q_W-1:0]  quo  [Q_W+1];
  logic [D2_W-1:0] dsr  [Q_W+1];
  logic [AW-1:0]   tag  [Q_W+1];
  logic [Q_W:0]    vld;

  // The quotient fits in Q_W bits, so the top dividend bits start below d2.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    rem[0] <= in_dvd[DVD_W-1:Q_W];
    low[0] <= in_dvd[Q_W-1:0];
    quo[0] <= '0;
    dsr[0] <= in_d2;
    tag[0] <= in_idx;
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [D2_W:0] trial;
    logic [D2_W:0] diff;
    logic          ge;

    always_comb begin
      trial = {rem[k-1], low[k-1][Q_W-1]};
      diff  = trial - {1'b0, dsr[k-1]};
      ge    = (trial >= {1'b0, dsr[k-1]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      rem[k] <= ge ? diff[D2_W-1:0] : trial[D2_W-1:0];
      low[k] <= {low[k-1][Q_W-2:0], 1'b0};
      quo[k] <= {quo[k-1][Q_W-2:0], ge};
      dsr[k] <= dsr[k-1];
      tag[k] <= tag[k-1];
    end
  end

  assign out_valid = vld[Q_W];
  assign out_q     = quo[Q_W];
  assign out_idx   = tag[Q_W];
  assign busy      = |vld;
endmodule

// ===== hdl/gradient_center_vote_accumulator_core.sv =====
// Top level: weight and score grids with a swept vote pipeline.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid / ready | kind, col, row, weight_value, grad_x, grad_y
//   rsp     | out | valid / ready | score
//
// Weight write: taken in S_IDLE. Score read and clear: stalls in S_RETRY while rsp is full.
// Vote: sweeps every cell, one cell per cycle from the weight RAM port, then drains
// the pipeline (4 front stages, 40 divide, 1 update) and returns to idle once it is
// empty.
// After reset every cell of the score RAM is cleared; req.ready
// stays low then and during every vote and read.
`timescale 1ns / 1ps
module gradient_center_vote_accumulator_core #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic       clk,
  input  logic       rst,
  gcva_req_if.sink   req,
  gcva_rsp_if.source rsp
);
  import gcva_pkg::*;

  localparam int CELLS = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int DXW   = ((CW > 6) ? CW : 6) + 1;
  localparam int DYW   = ((RW > 6) ? RW : 6) + 1;
  localparam int PW    = ((DXW > DYW) ? DXW : DYW) + 17;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_VOTE  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_READ  = 6'b010000,
    S_RETRY = 6'b100000
  } state_t;

  state_t state, state_next;

  logic            accept;
  logic            in_grid;
  logic [AW-1:0]   req_addr;
  logic            busy;
  logic            out_free;

  logic [AW-1:0]   clr_idx;
  logic [AW-1:0]   sw_idx;
  logic [CW-1:0]   sw_cx;
  logic [RW-1:0]   sw_cy;
  logic            sw_last;

  logic [5:0]         o_x;
  logic [5:0]         o_y;
  logic signed [15:0] g_x;
  logic signed [15:0] g_y;
  logic [AW-1:0]      rd_addr;
  logic               rd_in;

  logic               out_valid;
  logic [SCORE_W-1:0] out_score;

  // front of the vote pipeline
  logic                    s0_valid;
  logic [CW-1:0]           s0_cx;
  logic [RW-1:0]           s0_cy;
  logic [AW-1:0]           s0_idx;
  logic [7:0]              w_rdata;
  logic signed [DXW-1:0]   dx;
  logic signed [DYW-1:0]   dy;
  logic                    s1_valid;
  logic [AW-1:0]           s1_idx;
  logic [7:0]              s1_w;
  logic signed [DXW+15:0]  s1_px;
  logic signed [DYW+15:0]  s1_py;
  logic signed [2*DXW-1:0] s1_sx;
  logic signed [2*DYW-1:0] s1_sy;
  logic signed [PW-1:0]    n_sum;
  logic                    s2_valid;
  logic [AW-1:0]           s2_idx;
  logic [7:0]              s2_w;
  logic [N_W-1:0]          s2_n;
  logic [D2_W-1:0]         s2_d2;
  logic                    s3_valid;
  logic [AW-1:0]           s3_idx;
  logic [7:0]              s3_w;
  logic [NN_W-1:0]         s3_nn;
  logic [D2_W-1:0]         s3_d2;
  logic [DVD_W-1:0]        dvd;

  logic                    dv_valid;
  logic [Q_W-1:0]          dv_q;
  logic [AW-1:0]           dv_idx;
  logic                    dv_busy;

  logic                    t_valid;
  logic [Q_W-1:0]          t_q;
  logic [AW-1:0]           t_idx;
  logic [SCORE_W:0]        t_sum;

  logic                    w_we;
  logic                    sc_we;
  logic [AW-1:0]           sc_waddr;
  logic [SCORE_W-1:0]      sc_wdata;
  logic [AW-1:0]           sc_raddr;
  logic [SCORE_W-1:0]      sc_rdata;

  assign accept   = req.valid && req.ready;
  assign in_grid  = (32'(req.col) < GRID_COLS) && (32'(req.row) < GRID_ROWS);
  assign req_addr = AW'(32'(req.row) * GRID_COLS + 32'(req.col));
  assign req.ready = (state == S_IDLE);
  assign out_free = !out_valid || rsp.ready;
  assign sw_last  = (sw_idx == AW'(CELLS - 1));
  assign busy     = s0_valid || s1_valid || s2_valid || s3_valid || dv_busy || t_valid;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == AW'(CELLS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept && req.kind == KIND_VOTE && in_grid) state_next = S_VOTE;
        else if (accept && req.kind == KIND_READ) state_next = S_READ;
      end
      S_VOTE: begin
        if (sw_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!busy) state_next = S_IDLE;
      end
      S_READ: begin
        state_next = out_free ? S_IDLE : S_RETRY;
      end
      S_RETRY: begin
        state_next = S_READ;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (state == S_READ && out_free) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // latch the request and restart the sweep
  always_ff @(posedge clk) begin
    if (accept) begin
      o_x     <= req.col;
      o_y     <= req.row;
      g_x     <= req.grad_x;
      g_y     <= req.grad_y;
      rd_addr <= req_addr;
      rd_in   <= in_grid;
      sw_idx  <= '0;
      sw_cx   <= '0;
      sw_cy   <= '0;
    end else if (state == S_VOTE) begin
      sw_idx <= sw_idx + 1'b1;
      if (sw_cx == CW'(GRID_COLS - 1)) begin
        sw_cx <= '0;
        sw_cy <= sw_cy + 1'b1;
      end else begin
        sw_cx <= sw_cx + 1'b1;
      end
    end
    if (state == S_READ && out_free) begin
      out_score <= rd_in ? sc_rdata : '0;
    end
  end

  assign w_we = accept && req.kind == KIND_WEIGHT && in_grid;

  gcva_ram #(.WIDTH(8), .DEPTH(CELLS)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (req_addr),
    .wdata (req.weight_value),
    .raddr (sw_idx),
    .rdata (w_rdata)
  );

  always_comb begin
    dx    = signed'(DXW'(o_x) - DXW'(s0_cx));
    dy    = signed'(DYW'(o_y) - DYW'(s0_cy));
    n_sum = PW'(s1_px) + PW'(s1_py);
    dvd   = s3_nn * s3_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      t_valid  <= 1'b0;
    end else begin
      s0_valid <= (state == S_VOTE);
      s1_valid <= s0_valid;
      // drop cells facing away; the origin cell has n == 0 and drops too
      s2_valid <= s1_valid && !n_sum[PW-1] && (n_sum != '0);
      s3_valid <= s2_valid;
      t_valid  <= dv_valid;
    end
    s0_cx  <= sw_cx;
    s0_cy  <= sw_cy;
    s0_idx <= sw_idx;
    s1_idx <= s0_idx;
    s1_w   <= w_rdata;
    s1_px  <= dx * g_x;
    s1_py  <= dy * g_y;
    s1_sx  <= dx * dx;
    s1_sy  <= dy * dy;
    s2_idx <= s1_idx;
    s2_w   <= s1_w;
    s2_n   <= n_sum[N_W-1:0];
    s2_d2  <= D2_W'(s1_sx) + D2_W'(s1_sy);
    s3_idx <= s2_idx;
    s3_w   <= s2_w;
    s3_nn  <= s2_n * s2_n;
    s3_d2  <= s2_d2;
    t_q    <= dv_q;
    t_idx  <= dv_idx;
  end

  gcva_div #(.AW(AW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_dvd    (dvd),
    .in_d2     (s3_d2),
    .in_idx    (s3_idx),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_idx   (dv_idx),
    .busy      (dv_busy)
  );

  // each cell is touched once per vote, so the read-modify-write never overlaps
  assign t_sum = (SCORE_W + 1)'(sc_rdata) + (SCORE_W + 1)'(t_q);

  always_comb begin
    sc_we    = 1'b0;
    sc_waddr = rd_addr;
    sc_wdata = '0;
    if (state == S_CLEAR) begin
      sc_we    = 1'b1;
      sc_waddr = clr_idx;
    end else if (t_valid) begin
      sc_we    = 1'b1;
      sc_waddr = t_idx;
      sc_wdata = t_sum[SCORE_W] ? SCORE_MAX : t_sum[SCORE_W-1:0];
    end else if (state == S_READ && out_free && rd_in) begin
      sc_we = 1'b1;
    end
    case (state)
      S_IDLE:         sc_raddr = req_addr;
      S_VOTE, S_DRAIN: sc_raddr = dv_idx;
      default:        sc_raddr = rd_addr;
    endcase
  end

  gcva_ram #(.WIDTH(SCORE_W), .DEPTH(CELLS)) u_score_ram (
    .clk   (clk),
    .we    (sc_we),
    .waddr (sc_waddr),
    .wdata (sc_wdata),
    .raddr (sc_raddr),
    .rdata (sc_rdata)
  );

  assign rsp.valid = out_valid;
  assign rsp.score = out_score;

`ifndef NO_ASSERTIONS
  a_idle_empty : assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !busy)
    else $error("vote pipeline not empty while idle");

  a_full_retry : assert property (@(posedge clk) disable iff (rst)
    state == S_READ && out_valid && !rsp.ready |=> state == S_RETRY)
    else $error("read result would overwrite a pending response");

  a_no_update_in_clear : assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !t_valid && !busy)
    else $error("score update during clearing pass");

  a_reset_clears : assert property (@(posedge clk)
    rst |=> state == S_CLEAR && clr_idx == '0)
    else $error("reset did not start the clearing pass");
`endif
endmodule
